// ===== hw/rtl/tdp_pkg.sv =====
// Shared widths, types and state codes for the trial-division prime tester.
// Used by tdp_rem and trial_division_prime_test; no dependencies.
`default_nettype none
package tdp_pkg;
	localparam int WIDTH  = 32;            // bits of the tested value, sign included
	localparam int NUM_W  = 32;            // width of the number field on the port
	localparam int DW     = WIDTH / 2 + 1; // divisor width, covers sqrt of the largest value
	localparam int SQW    = WIDTH + 1;     // running square of the divisor
	localparam int CW     = $clog2(WIDTH); // bit counter of the serial remainder
	localparam int OUT_W  = 8;             // is_prime padded to a byte

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_FINISH
	} tdp_state_t;

	typedef struct packed {
		logic done;  // one-cycle pulse, remainder ready
		logic zero;  // remainder is zero, valid with done
	} tdp_rem_status_t;
endpackage
`default_nettype wire

// ===== hw/rtl/tdp_rem.sv =====
// Bit-serial restoring remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on tdp_pkg.
`default_nettype none
module tdp_rem (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [tdp_pkg::WIDTH-1:0]   dividend,
	input  wire logic [tdp_pkg::DW-1:0]      divisor,
	output tdp_pkg::tdp_rem_status_t         status
);
	import tdp_pkg::*;

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [WIDTH-1:0] shift_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   div_q;
	logic [DW:0]     trial;
	logic [DW:0]     diff;
	logic [DW-1:0]   rem_next;

	// shift the next dividend bit into the partial remainder
	assign trial    = {rem_q, shift_q[WIDTH-1]};
	assign diff     = trial - {1'b0, div_q};
	assign rem_next = (trial >= {1'b0, div_q}) ? diff[DW-1:0] : trial[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// pulse on the last shift
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			div_q   <= divisor;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[WIDTH-2:0], 1'b0};
			rem_q   <= rem_next;
		end
	end

	assign status = '{done: done_q, zero: (rem_q == '0)};
endmodule
`default_nettype wire

// ===== hw/rtl/trial_division_prime_test.sv =====
// Top level of the trial-division prime tester: stream ports, divisor sequencer, result register.
// Depends on tdp_pkg and tdp_rem.
//
//  channel  | direction | tdata bits (low first)   | tuser/tlast
//  s_axis   | in        | [31:0] number (signed)   | none
//  m_axis   | out       | [0] is_prime, [7:1] zero | none
//
// Each trial divisor takes one bound check, then WIDTH steps of the
// bit-serial remainder unit and its done pulse. A value below two or negative
// goes straight to the result; else divisors run from 2 up until one divides
// the value or its square exceeds it. One item is worked at a time.
// The result waits in an output register; a new item is taken while it waits.
// Reset clears the sequencer and the output valid; nothing else is kept.
`default_nettype none
module trial_division_prime_test (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [tdp_pkg::NUM_W-1:0]    s_axis_tdata,   // [31:0] number
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [tdp_pkg::OUT_W-1:0]         m_axis_tdata    // [0] is_prime, rest zero
);
	import tdp_pkg::*;

	tdp_state_t      state_q, state_d;
	logic [WIDTH-1:0] num_q;
	logic [DW-1:0]   div_q;
	logic [SQW-1:0]  sq_q;
	logic            res_q;
	logic            out_valid_q;
	logic            out_data_q;
	logic            rem_start;
	logic            in_take;
	logic            out_load;
	logic [WIDTH-1:0] num_in;
	logic            small_in;
	logic            over_bound;
	tdp_rem_status_t rem_status;

	assign num_in     = WIDTH'(signed'(s_axis_tdata));
	assign small_in   = num_in[WIDTH-1] || (num_in[WIDTH-1:1] == '0);
	assign over_bound = sq_q > {1'b0, num_q};
	assign in_take    = s_axis_tvalid && s_axis_tready;

	tdp_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (num_q),
		.divisor  (div_q),
		.status   (rem_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		rem_start     = 1'b0;
		out_load      = 1'b0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = small_in ? ST_FINISH : ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (over_bound) begin
					state_d = ST_FINISH;
				end else begin
					rem_start = 1'b1;
					state_d   = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (rem_status.done) begin
					state_d = rem_status.zero ? ST_FINISH : ST_CHECK;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// divisor, running square and verdict
	always_ff @(posedge clk) begin
		if (in_take) begin
			num_q <= num_in;
			div_q <= DW'(2);
			sq_q  <= SQW'(4);
			res_q <= 1'b0;
		end else if (state_q == ST_CHECK && over_bound) begin
			res_q <= 1'b1;
		end else if (state_q == ST_DIVIDE && rem_status.done && !rem_status.zero) begin
			// advance: (d+1)^2 = d^2 + 2d + 1
			div_q <= div_q + 1'b1;
			sq_q  <= sq_q + SQW'({div_q, 1'b1});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W-1){1'b0}}, out_data_q};
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Stream-level testbench for trial_division_prime_test: directed values, then random ones.
// Checks each is_prime byte against a trial-division predictor kept in the bench.
// Depends on tdp_pkg and the RTL of trial_division_prime_test.
`timescale 1ns / 1ps
module tb_top;
	import tdp_pkg::*;

	localparam int STALL_LIMIT  = 200000; // longest run with no item moving before a timeout
	localparam int RANDOM_ITEMS = 78;
	localparam int TAIL_CYCLES  = 50;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [NUM_W-1:0]     s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_W-1:0]     m_axis_tdata;

	logic [NUM_W-1:0]     numbers_to_send[$];
	logic [OUT_W-1:0]     verdicts_due[$];
	logic                 input_taken = 1'b0;
	int                   burst_left = 0;
	int                   gap_left = 0;
	int                   ready_left = 0;
	int                   idle_cycles = 0;
	int                   error_count = 0;

	trial_division_prime_test u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Take the low WIDTH bits; a set sign bit, zero and one are never prime.
	function automatic logic prime_verdict(logic [NUM_W-1:0] word);
		longint unsigned value;
		longint unsigned divisor;
		value = longint'(word) & ({64{1'b1}} >> (64 - WIDTH));
		if (((value >> (WIDTH - 1)) & 1) != 0)
			return 1'b0;
		if (value <= 1)
			return 1'b0;
		for (divisor = 2; divisor <= value / divisor; divisor++) begin
			if (value % divisor == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what);
		$display("ERROR at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// Sender: bursts of items, random gaps after a burst ends.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || input_taken) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (numbers_to_send.size() > 0) begin
				s_axis_tdata <= numbers_to_send.pop_front();
				s_axis_tvalid <= 1'b1;
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(0, 6);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: short and long stalls between ready stretches.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (ready_left > 0) begin
			ready_left <= ready_left - 1;
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					m_axis_tready <= 1'b0;
					ready_left <= $urandom_range(1, 6);
				end
				1: begin
					m_axis_tready <= 1'b0;
					ready_left <= $urandom_range(10, 40);
				end
				default: begin
					m_axis_tready <= 1'b1;
					ready_left <= $urandom_range(1, 30);
				end
			endcase
		end
	end

	// Predict on input items, compare on output items, watch for a hang.
	always @(posedge clk) begin
		logic [OUT_W-1:0] due;
		if (arst_n) begin
			input_taken <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready)
				verdicts_due.push_back(OUT_W'(prime_verdict(s_axis_tdata)));
			if (m_axis_tvalid && m_axis_tready) begin
				if (verdicts_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
				end else begin
					due = verdicts_due.pop_front();
					if (m_axis_tdata !== due)
						report_mismatch($sformatf("is_prime byte %h, want %h", m_axis_tdata, due));
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
				$display("trial_division_prime_test: mismatch");
				$finish;
			end
		end
	end

	initial begin
		logic [NUM_W-1:0] value;
		int unsigned factor;
		int unsigned small_primes[6] = '{2, 3, 5, 7, 11, 13};

		// zero, one, two and small primes and composites
		numbers_to_send = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd97};
		// negatives
		numbers_to_send.push_back(32'hFFFF_FFFF);
		numbers_to_send.push_back(32'h8000_0000);
		numbers_to_send.push_back(32'hAAAA_AAAA);
		// divisor bound met with equality (square of a prime), other primes and composites
		numbers_to_send.push_back(32'd63001);
		numbers_to_send.push_back(32'd65521);
		numbers_to_send.push_back(32'd65536);
		numbers_to_send.push_back(32'd1000003);
		numbers_to_send.push_back(32'd1022117);
		// large values with small factors
		numbers_to_send.push_back(32'h7FFF_FFFE);
		numbers_to_send.push_back(32'd2147483645);
		numbers_to_send.push_back(32'd2147483643);
		numbers_to_send.push_back(32'h5555_5555);
		numbers_to_send.push_back(32'h2AAA_AAAA);
		numbers_to_send.push_back(32'h1234_5678);

		// keep large values cheap: negatives or multiples of a small prime
		repeat (RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1: value = $urandom | 32'h8000_0000;
				2, 3, 4, 5: value = $urandom_range(0, 4095);
				6, 7: value = $urandom_range(4096, 65535);
				default: begin
					factor = small_primes[$urandom_range(0, 5)];
					value = $urandom & 32'h7FFF_FFFF;
					value = value - value % factor;
				end
			endcase
			numbers_to_send.push_back(value);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (numbers_to_send.size() > 0 || s_axis_tvalid || verdicts_due.size() > 0);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (verdicts_due.size() > 0)
			report_mismatch($sformatf("%0d results never arrived", verdicts_due.size()));
		if (error_count == 0)
			$display("trial_division_prime_test: match");
		else
			$display("trial_division_prime_test: mismatch");
		$finish;
	end
endmodule
